@@ sv/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with search.
`default_nettype none

package bdq_pkg;

    // Default number of entry slots held by the ring buffer.
    localparam int DEPTH_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_SEARCH     = 2'd2,
        OP_DUMP       = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_ENTRY    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DUMP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;       // latch the search key of the accepted word
        logic    push_front;
        logic    push_back;
        logic    scan_start;   // rewind the scan to the front entry
        logic    rd_issue;     // read the next entry of the scan
        logic    rd_take;      // the pending read data has been used
        logic    scan_stop;    // drop any read still in flight
        logic    out_load;     // load the output register
        t_status out_status;
        logic    out_use_data; // output data comes from the read entry
        logic    out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;  // output register can take a word this cycle
        logic rd_vld;    // read data register holds an unused entry
        logic rd_last;   // that entry is the back of the queue
        logic match;     // that entry equals the search key
        logic idx_done;  // every held entry has been read
    } t_stat;

endpackage

`default_nettype wire

@@ sv/bdq_dpath.sv @@
// Datapath of the deque: entry memory, pointers, scan counter and output register.
`default_nettype none

module bdq_dpath #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bdq_pkg::t_cmd                i_cmd,
    output bdq_pkg::t_stat                    o_stat,
    input  wire logic [bdq_pkg::VALUE_W-1:0]  i_value,
    input  wire logic [bdq_pkg::VALUE_W-1:0]  i_key,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [bdq_pkg::STATUS_W-1:0]      o_out_status,
    output logic [bdq_pkg::VALUE_W-1:0]       o_out_data,
    output logic                              o_out_last
);
    import bdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic [AW-1:0]      r_front;
    logic [AW-1:0]      r_back;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_idx;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic [VALUE_W-1:0] r_rd_data;
    logic [VALUE_W-1:0] r_key;
    logic               r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0] r_out_data;
    logic               r_out_last;

    logic [AW-1:0]      n_front;
    logic [AW-1:0]      n_back;
    logic [AW-1:0]      n_rd_ptr;
    logic [CW-1:0]      n_idx;
    logic               w_full;
    logic               w_out_free;

    assign n_front  = (r_front == '0) ? LAST_SLOT : r_front - 1'b1;
    assign n_back   = (r_back == LAST_SLOT) ? '0 : r_back + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
    assign n_idx    = r_idx + 1'b1;
    assign w_full   = (r_count == FULL_CNT);
    assign w_out_free = !r_out_vld || i_out_ready;

    // Entry storage: one write port for pushes, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_front) begin
            r_mem[n_front] <= i_value;
        end else if (i_cmd.push_back) begin
            r_mem[r_back] <= i_value;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= n_front;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.push_back) begin
                r_back  <= n_back;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Scan pointer, counter and the pending-read flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.scan_stop || i_cmd.scan_start) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.rd_issue) begin
            r_rd_vld <= 1'b1;
        end else if (i_cmd.rd_take) begin
            r_rd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_ptr <= r_front;
            r_idx    <= '0;
        end else if (i_cmd.rd_issue) begin
            r_rd_ptr  <= n_rd_ptr;
            r_idx     <= n_idx;
            r_rd_last <= (n_idx == r_count);
        end
        if (i_cmd.accept) begin
            r_key <= i_key;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_data   <= i_cmd.out_use_data ? r_rd_data : '0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    always_comb begin
        o_stat.empty    = (r_count == '0);
        o_stat.full     = w_full;
        o_stat.out_free = w_out_free;
        o_stat.rd_vld   = r_rd_vld;
        o_stat.rd_last  = r_rd_last;
        o_stat.match    = (r_rd_data == r_key);
        o_stat.idx_done = (r_idx == r_count);
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push_front || i_cmd.push_back) |-> !w_full)
        else $error("push into a full queue");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> w_out_free)
        else $error("output word overwritten before it was taken");

    a_stop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_stop |=> !r_rd_vld)
        else $error("read left pending after the scan ended");

    a_no_overread: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_idx < r_count))
        else $error("scan read beyond the held entries");

endmodule

`default_nettype wire

@@ sv/bdq_ctrl.sv @@
// Controller state machine of the deque: operation decode and scan sequencing.
`default_nettype none

module bdq_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic [bdq_pkg::OP_W-1:0]  i_opcode,
    output logic                           o_in_ready,
    input  wire bdq_pkg::t_stat            i_stat,
    output bdq_pkg::t_cmd                  o_cmd
);
    import bdq_pkg::*;

    t_state r_state;
    t_state n_state;
    t_op    w_op;

    assign w_op = t_op'(i_opcode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.out_status = ST_INSERTED;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    o_cmd.accept   = 1'b1;
                    o_cmd.out_last = 1'b1;
                    case (w_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            o_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.out_status = ST_INSERTED;
                                o_cmd.push_front = (w_op == OP_PUSH_FRONT);
                                o_cmd.push_back  = (w_op == OP_PUSH_BACK);
                            end
                        end
                        OP_SEARCH, OP_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state = (w_op == OP_SEARCH) ? S_SEARCH : S_DUMP;
                            end
                        end
                        default: begin
                            o_cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (i_stat.rd_vld) begin
                    if (i_stat.match || i_stat.rd_last) begin
                        if (i_stat.out_free) begin
                            o_cmd.rd_take    = 1'b1;
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = i_stat.match ? ST_PRESENT : ST_ABSENT;
                            o_cmd.scan_stop  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        o_cmd.rd_take = 1'b1;
                    end
                end
                o_cmd.rd_issue = !i_stat.idx_done && !o_cmd.scan_stop &&
                                 (!i_stat.rd_vld || o_cmd.rd_take);
            end
            S_DUMP: begin
                if (i_stat.rd_vld && i_stat.out_free) begin
                    o_cmd.rd_take      = 1'b1;
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_status   = ST_ENTRY;
                    o_cmd.out_use_data = 1'b1;
                    o_cmd.out_last     = i_stat.rd_last;
                    if (i_stat.rd_last) begin
                        o_cmd.scan_stop = 1'b1;
                        n_state = S_IDLE;
                    end
                end
                o_cmd.rd_issue = !i_stat.idx_done && !o_cmd.scan_stop &&
                                 (!i_stat.rd_vld || o_cmd.rd_take);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == S_IDLE))
        else $error("input taken while a scan is running");

    a_dump_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP && o_cmd.out_load) |-> (o_cmd.out_status == ST_ENTRY))
        else $error("dump produced a word that is not an entry");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && o_cmd.out_last && o_cmd.out_load) |=> (r_state == S_IDLE))
        else $error("scan continued after its last word");

endmodule

`default_nettype wire

@@ sv/bounded_deque_with_search.sv @@
// Top level of the bounded double-ended queue with search and dump.
//
// A bounded double-ended queue of 32-bit signed values held in a ring buffer
// of DEPTH slots. Each input word carries an operation in s_axis_tuser:
// push front, push back, search for a key, or dump all entries. A push when
// the queue is full drops the value and reports full. Every input word
// produces at least one output word, and the final one has tlast set.
// A push or any operation on an empty queue answers with one word, in the cycle
// after it is accepted. A search reads one entry per cycle from the front
// through the entry memory's single registered read port, stopping early on
// the first match. While the receiver is ready, a dump sends one entry per
// cycle from front to back; the scan is rewound at acceptance, and each entry
// passes through the read register into the output register. A new input
// word is taken only once the previous one has sent all its output words
// and the output register is free or being emptied. When the receiver holds
// m_axis_tready low, the output word holds and a dump pauses with one
// entry waiting in the read register. After reset the queue is empty; the
// entry memory is not cleared, since only held entries are ever read.
`default_nettype none

module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // [31:0] value, [63:32] key
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] data
    output logic [2:0]       m_axis_tuser,  // [2:0] status
    output logic             m_axis_tlast
);
    import bdq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller decodes the operation and sequences the scan.
    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the entries, the ring pointers and the output word.
    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_value      (s_axis_tdata[31:0]),
        .i_key        (s_axis_tdata[63:32]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the bounded deque with search, with random stalls.
`default_nettype none

module testbench;
    import bdq_pkg::*;

    localparam int SLOTS        = DEPTH_DEF;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_PRINTED  = 40;

    // One output word as the queue should answer it.
    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic               last;
    } t_reply;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] value, [63:32] key
    logic [1:0]  s_axis_tuser;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] data
    logic [2:0]  m_axis_tuser;   // [2:0] status
    logic        m_axis_tlast;

    bounded_deque_with_search #(
        .DEPTH(SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Shadow copy of the ring buffer, updated when a word is accepted.
    logic signed [31:0] shadow_slot [SLOTS];
    logic [SLOT_W-1:0]  shadow_front;
    logic [SLOT_W:0]    shadow_count;
    t_reply             deque_replies [$];

    int mismatches    = 0;
    int cycle_count   = 0;
    int items_sent    = 0;
    int words_checked = 0;
    int drops_seen    = 0;
    int hits_seen     = 0;
    int dumps_seen    = 0;
    int hold_req      = 0;   // cycles the receiver must hold off, picked up by its process
    bit idle_on       = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic logic signed [31:0] held_at(int pos);
        return shadow_slot[(shadow_front + pos) % SLOTS];
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            default: return -32'sd1;
        endcase
    endfunction

    // Applies one accepted word to the shadow queue and queues its answer words.
    task automatic shadow_deque_op(t_op op, logic signed [31:0] value,
                                   logic signed [31:0] key);
        bit found;
        found = 1'b0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (shadow_count == SLOTS) begin
                    // A full queue drops the value and keeps its contents.
                    deque_replies.push_back('{status: ST_FULL, data: '0, last: 1'b1});
                    drops_seen++;
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        shadow_front = SLOT_W'((shadow_front + SLOTS - 1) % SLOTS);
                        shadow_slot[shadow_front] = value;
                    end else begin
                        shadow_slot[(shadow_front + shadow_count) % SLOTS] = value;
                    end
                    shadow_count++;
                    deque_replies.push_back('{status: ST_INSERTED, data: '0, last: 1'b1});
                end
            end
            OP_SEARCH: begin
                if (shadow_count == 0) begin
                    deque_replies.push_back('{status: ST_EMPTY, data: '0, last: 1'b1});
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (held_at(i) == key) found = 1'b1;
                    end
                    if (found) hits_seen++;
                    deque_replies.push_back('{status: found ? ST_PRESENT : ST_ABSENT,
                                              data: '0, last: 1'b1});
                end
            end
            default: begin
                if (shadow_count == 0) begin
                    deque_replies.push_back('{status: ST_EMPTY, data: '0, last: 1'b1});
                end else begin
                    dumps_seen++;
                    for (int i = 0; i < shadow_count; i++) begin
                        deque_replies.push_back('{status: ST_ENTRY, data: held_at(i),
                                                  last: (i == shadow_count - 1)});
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endtask

    // Offers one word after a random gap and returns at the edge where it is taken.
    // Valid stays high after acceptance; a pause or a gap in the next call lowers it.
    task automatic send_word(t_op op, logic signed [31:0] value, logic signed [31:0] key);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {key, value};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow_deque_op(op, value, key);
        items_sent++;
    endtask

    // Sender stops offering until every queued answer word has arrived.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (deque_replies.size() != 0) @(posedge i_clk);
    endtask

    // One random word. Keys often hit a held entry and values often repeat one,
    // so searches find matches at every position and duplicates get stored.
    task automatic send_random_word(int push_pct, int dump_pct);
        int                 r;
        t_op                op;
        logic signed [31:0] value;
        logic signed [31:0] key;
        r     = $urandom_range(0, 99);
        value = $urandom;
        key   = $urandom;
        if ($urandom_range(0, 7) == 0) value = pick_extreme();
        if ($urandom_range(0, 7) == 0) key = pick_extreme();
        if (shadow_count != 0 && $urandom_range(0, 1) == 1)
            key = held_at($urandom_range(0, shadow_count - 1));
        if (shadow_count != 0 && $urandom_range(0, 3) == 0)
            value = held_at($urandom_range(0, shadow_count - 1));
        if (r < push_pct)
            op = ($urandom_range(0, 1) == 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (r < push_pct + dump_pct)
            op = OP_DUMP;
        else
            op = OP_SEARCH;
        send_word(op, value, key);
    endtask

    // Receiver: random stall before each word, or a long hold when one is requested.
    initial begin
        int stall;
        int hold;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req > 0) begin
                hold     = hold_req;
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready) && hold_req == 0);
        end
    end

    // Each word taken from the block is compared with the oldest answer owed.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (deque_replies.size() == 0) begin
                report_mismatch($sformatf("word with nothing owed: status %0d data %h last %b",
                                          m_axis_tuser, m_axis_tdata, m_axis_tlast));
            end else begin
                want = deque_replies.pop_front();
                words_checked++;
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tdata !== want.data)
                    report_mismatch($sformatf("data %h, want %h", m_axis_tdata, want.data));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_axis_tlast, want.last));
            end
        end
    end

    // Search and dump on the queue right after reset.
    task automatic test_empty_queue();
        send_word(OP_SEARCH, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(OP_DUMP, 32'sh0000_0000, -32'sd1);
        send_word(OP_SEARCH, -32'sd1, 32'sh7FFF_FFFF);
        pause_until_drained();
    endtask

    // Extreme values at both ends, a repeated value, hits at the front and further in, a miss.
    task automatic test_first_pushes();
        send_word(OP_PUSH_FRONT, 32'sh8000_0000, 32'sh0000_0000);
        send_word(OP_PUSH_BACK, 32'sh7FFF_FFFF, -32'sd1);
        send_word(OP_PUSH_FRONT, 32'sh0000_0000, 32'sh0000_0000);
        send_word(OP_PUSH_BACK, -32'sd1, 32'sh8000_0000);
        send_word(OP_PUSH_BACK, 32'sh7FFF_FFFF, 32'sh0000_0000);
        send_word(OP_SEARCH, 32'sh0000_0000, 32'sh0000_0000);
        send_word(OP_SEARCH, 32'sh0000_0000, 32'sh7FFF_FFFF);
        send_word(OP_SEARCH, 32'sh0000_0000, 32'sh8000_0000);
        send_word(OP_SEARCH, 32'sh0000_0000, 32'sh1234_5678);
        send_word(OP_DUMP, 32'sh5555_5555, 32'shAAAA_AAAA);
        pause_until_drained();
    endtask

    // Few pushes among many searches and dumps, so scans run at each fill level the pushes reach.
    task automatic test_random_fill(int count);
        for (int i = 0; i < count; i++) begin
            idle_on = (i % 60) >= 15;
            send_random_word(12, 30);
        end
        idle_on = 1'b1;
        pause_until_drained();
    endtask

    // Top the queue up; pushes at both ends drop, its ends are searched, a full dump follows.
    task automatic test_full_queue();
        while (shadow_count < SLOTS) send_word(OP_PUSH_BACK, $urandom, $urandom);
        send_word(OP_PUSH_FRONT, -32'sd1, 32'sh0000_0000);
        send_word(OP_PUSH_BACK, 32'sh0000_0000, -32'sd1);
        send_word(OP_SEARCH, 32'sh0000_0000, held_at(0));
        send_word(OP_SEARCH, 32'sh0000_0000, held_at(SLOTS - 1));
        send_word(OP_DUMP, 32'sh0000_0000, 32'sh0000_0000);
        pause_until_drained();
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the
    // block stalls its input; then the sender waits for every owed word.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 300;
        repeat (25) send_random_word(20, 40);
        pause_until_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_full(int count);
        for (int i = 0; i < count; i++) begin
            idle_on = (i % 50) >= 12;
            send_random_word(20, 25);
        end
        idle_on = 1'b1;
        pause_until_drained();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUSH_FRONT;
        shadow_front  = '0;
        shadow_count  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_first_pushes();
        test_random_fill(200);
        test_full_queue();
        test_backpressure();
        test_random_full(220);

        while (deque_replies.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 8) @(posedge i_clk);

        $display("summary: %0d words sent, %0d answer words checked, %0d mismatches",
                 items_sent, words_checked, mismatches);
        $display("summary: %0d dumps, %0d search hits, %0d pushes dropped on a full queue",
                 dumps_seen, hits_seen, drops_seen);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
sv/bdq_pkg.sv
sv/bdq_dpath.sv
sv/bdq_ctrl.sv
sv/bounded_deque_with_search.sv
sim/testbench.sv
